@@ sv/srt_pkg.sv @@
// shared types and constants for the sorted region table
// used by srt_first, srt_cell and sorted_region_table
package srt_pkg;

	localparam int MAX_REGIONS = 128;
	localparam int ADDR_BITS   = 48;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int COUNT_W     = 16;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_REG    = 2'd0,
		FN_UNREG  = 2'd1,
		FN_LOOKUP = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_OVERLAP    = 3'd1,
		STS_FULL       = 3'd2,
		STS_NOT_FOUND  = 3'd3,
		STS_RANGE      = 3'd4,
		STS_COUNT_FULL = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SEL,
		S_RD,
		S_ACT
	} state_t;

	typedef enum logic [2:0] {
		AK_NONE,
		AK_REPORT,
		AK_INC,
		AK_UNREG,
		AK_INSERT,
		AK_CLEAR
	} act_kind_t;

	typedef enum logic [2:0] {
		CO_HOLD,
		CO_INSERT,
		CO_REMOVE,
		CO_INC,
		CO_DEC
	} cell_op_t;

	typedef struct packed {
		addr_t               start;
		addr_t               length;
		logic [COUNT_W-1:0]  count;
	} cell_data_t;

	localparam int CELL_W = $bits(cell_data_t);

	typedef struct packed {
		logic eq;
		logic leneq;
		logic ovl;
		logic holds;
		logic lt;
		logic fail;
	} cell_flags_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  idx;
		addr_t             start;
		addr_t             length;
	} cell_cmd_t;

	typedef struct packed {
		act_kind_t               kind;
		status_t                 status;
		logic [IDX_W-1:0]        idx;
		logic [MAX_REGIONS-1:0]  oh;
	} act_t;

endpackage

@@ sv/srt_first.sv @@
// find-first-set over the per-cell flag vector, one-hot and encoded
// depends on srt_pkg
module srt_first
	import srt_pkg::*;
(
	input  logic [MAX_REGIONS-1:0] vec,
	output logic                   any,
	output logic [IDX_W-1:0]       idx,
	output logic [MAX_REGIONS-1:0] oh
);

	always_comb begin
		oh  = vec & (~vec + MAX_REGIONS'(1));
		any = |vec;
		idx = '0;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			if (oh[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

@@ sv/srt_cell.sv @@
// one table slot: holds a region, compares it against the broadcast request
// and shifts to or from its neighbors; depends on srt_pkg
module srt_cell
	import srt_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] slot,
	input  logic             occ,
	input  addr_t            req_addr,
	input  addr_t            req_len,
	input  logic [ADDR_BITS:0] req_end,
	input  cell_cmd_t        cmd,
	input  cell_data_t       left,
	input  cell_data_t       right,
	output cell_data_t       data,
	output cell_flags_t      flags
);

	cell_data_t         data_q;
	cell_flags_t        flags_q;
	cell_flags_t        flags_c;
	logic [ADDR_BITS:0] end_c;

	always_comb begin
		end_c         = {1'b0, data_q.start} + {1'b0, data_q.length};
		flags_c.lt    = occ && (data_q.start < req_addr);
		flags_c.eq    = occ && (data_q.start == req_addr);
		flags_c.leneq = (data_q.length == req_len);
		// region below the request overlaps if the request starts before its end,
		// region at or above it overlaps if it starts before the request end
		flags_c.ovl   = occ && (flags_c.lt ? ({1'b0, req_addr} < end_c)
		                                   : ({1'b0, data_q.start} < req_end));
		flags_c.holds = flags_c.eq || (flags_c.lt && ({1'b0, req_addr} < end_c));
		flags_c.fail  = req_end > end_c;
	end

	always_ff @(posedge clk) begin
		flags_q <= flags_c;
		case (cmd.op)
			CO_INSERT: begin
				if (slot > cmd.idx) begin
					data_q <= left;
				end else if (slot == cmd.idx) begin
					data_q.start  <= cmd.start;
					data_q.length <= cmd.length;
					data_q.count  <= COUNT_W'(1);
				end
			end
			CO_REMOVE: begin
				if (slot >= cmd.idx) begin
					data_q <= right;
				end
			end
			CO_INC: begin
				if (slot == cmd.idx) begin
					data_q.count <= data_q.count + COUNT_W'(1);
				end
			end
			CO_DEC: begin
				if (slot == cmd.idx) begin
					data_q.count <= data_q.count - COUNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign data  = data_q;
	assign flags = flags_q;

endmodule

@@ sv/sorted_region_table.sv @@
// sorted region table top level: a chain of MAX_REGIONS cells kept sorted by start.
// each request goes through compare, select, read and act; act registers the result
// and waits while an older result is stalled. no new request is taken until act ends.
// the next request is taken while a result still waits at the output register.
// reset (arst_n low, asynchronous) empties the table and clears both channels.
module sorted_region_table
	import srt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [ADDR_BITS-1:0] length,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    entry_index,
	output logic [COUNT_W-1:0]  ref_count,
	output logic [ADDR_BITS-1:0] region_start
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   used_q, used_d;
	logic               advance;

	func_t              func_s1;
	addr_t              addr_s1;
	addr_t              len_s1;
	logic [ADDR_BITS:0] end_s1;

	cell_data_t  cell_data  [MAX_REGIONS];
	cell_flags_t cell_flags [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] occ;
	logic [MAX_REGIONS-1:0] eq_vec, leneq_vec, ovl_vec, holds_vec, ge_vec, fail_vec;
	cell_cmd_t   cmd;
	cell_op_t    cmd_op;

	logic                   eq_any, ovl_any, holds_any, pos_any;
	logic [IDX_W-1:0]       eq_idx, ovl_idx, holds_idx, pos_idx;
	logic [MAX_REGIONS-1:0] eq_oh, ovl_oh, holds_oh, pos_oh;

	act_t              act_q, act_d;
	logic [CELL_W-1:0] rd_mux;
	cell_data_t        rd_q;

	logic                out_valid_q;
	status_t             status_q, res_status;
	logic [IDX_W-1:0]    entry_index_q, res_idx;
	logic [COUNT_W-1:0]  ref_count_q, res_count;
	addr_t               region_start_q, res_start;

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func_t'(func);
			addr_s1 <= addr;
			len_s1  <= length;
			end_s1  <= {1'b0, addr} + {1'b0, length};
		end
	end

	// cell chain
	genvar g;
	generate
		for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
			cell_data_t left_c, right_c;
			assign occ[g]       = (CNT_W'(g) < used_q);
			assign eq_vec[g]    = cell_flags[g].eq;
			assign leneq_vec[g] = cell_flags[g].leneq;
			assign ovl_vec[g]   = cell_flags[g].ovl;
			assign holds_vec[g] = cell_flags[g].holds;
			assign ge_vec[g]    = !cell_flags[g].lt;
			assign fail_vec[g]  = cell_flags[g].fail;
			if (g == 0) begin : g_first
				assign left_c = cell_data[g];
			end else begin : g_mid
				assign left_c = cell_data[g-1];
			end
			if (g == MAX_REGIONS - 1) begin : g_last
				assign right_c = cell_data[g];
			end else begin : g_inner
				assign right_c = cell_data[g+1];
			end
			srt_cell u_cell (
				.clk      (clk),
				.slot     (IDX_W'(g)),
				.occ      (occ[g]),
				.req_addr (addr_s1),
				.req_len  (len_s1),
				.req_end  (end_s1),
				.cmd      (cmd),
				.left     (left_c),
				.right    (right_c),
				.data     (cell_data[g]),
				.flags    (cell_flags[g])
			);
		end
	endgenerate

	srt_first u_first_eq    (.vec(eq_vec),    .any(eq_any),    .idx(eq_idx),    .oh(eq_oh));
	srt_first u_first_ovl   (.vec(ovl_vec),   .any(ovl_any),   .idx(ovl_idx),   .oh(ovl_oh));
	srt_first u_first_holds (.vec(holds_vec), .any(holds_any), .idx(holds_idx), .oh(holds_oh));
	// insertion point: first slot that is free or not below the new start
	srt_first u_first_pos   (.vec(ge_vec),    .any(pos_any),   .idx(pos_idx),   .oh(pos_oh));

	// select: decide what the request does
	always_comb begin
		act_d.kind   = AK_NONE;
		act_d.status = STS_NOT_FOUND;
		act_d.idx    = '0;
		act_d.oh     = '0;
		case (func_s1)
			FN_REG: begin
				if (eq_any) begin
					act_d.idx = eq_idx;
					act_d.oh  = eq_oh;
					if (|(eq_oh & leneq_vec)) begin
						act_d.kind   = AK_INC;
						act_d.status = STS_OK;
					end else begin
						act_d.kind   = AK_REPORT;
						act_d.status = STS_OVERLAP;
					end
				end else if (ovl_any) begin
					act_d.kind   = AK_REPORT;
					act_d.status = STS_OVERLAP;
					act_d.idx    = ovl_idx;
					act_d.oh     = ovl_oh;
				end else if (used_q == CNT_W'(MAX_REGIONS) || !pos_any) begin
					act_d.status = STS_FULL;
				end else begin
					act_d.kind   = AK_INSERT;
					act_d.status = STS_OK;
					act_d.idx    = pos_idx;
					act_d.oh     = pos_oh;
				end
			end
			FN_UNREG: begin
				if (eq_any) begin
					act_d.kind   = AK_UNREG;
					act_d.status = STS_OK;
					act_d.idx    = eq_idx;
					act_d.oh     = eq_oh;
				end
			end
			FN_LOOKUP: begin
				if (holds_any) begin
					act_d.kind   = AK_REPORT;
					act_d.status = (|(holds_oh & fail_vec)) ? STS_RANGE : STS_OK;
					act_d.idx    = holds_idx;
					act_d.oh     = holds_oh;
				end
			end
			FN_CLEAR: begin
				act_d.kind   = AK_CLEAR;
				act_d.status = STS_OK;
			end
			default: ;
		endcase
	end

	// read the chosen cell
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			rd_mux = rd_mux | (cell_data[i] & {CELL_W{act_q.oh[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL) begin
			act_q <= act_d;
		end
		if (state_q == S_RD) begin
			rd_q <= cell_data_t'(rd_mux);
		end
	end

	// act: result fields and table update
	always_comb begin
		res_status = act_q.status;
		res_idx    = act_q.idx;
		res_count  = rd_q.count;
		res_start  = rd_q.start;
		cmd_op     = CO_HOLD;
		used_d     = used_q;
		case (act_q.kind)
			AK_REPORT: ;
			AK_NONE: begin
				res_idx   = '0;
				res_count = '0;
				res_start = '0;
			end
			AK_CLEAR: begin
				res_idx   = '0;
				res_count = '0;
				res_start = '0;
				used_d    = '0;
			end
			AK_INC: begin
				if (rd_q.count == COUNT_MAX) begin
					res_status = STS_COUNT_FULL;
				end else begin
					res_count = rd_q.count + COUNT_W'(1);
					cmd_op    = CO_INC;
				end
			end
			AK_UNREG: begin
				if (rd_q.count > COUNT_W'(1)) begin
					res_count = rd_q.count - COUNT_W'(1);
					cmd_op    = CO_DEC;
				end else begin
					res_count = '0;
					res_start = addr_s1;
					cmd_op    = CO_REMOVE;
					used_d    = used_q - CNT_W'(1);
				end
			end
			AK_INSERT: begin
				res_count = COUNT_W'(1);
				res_start = addr_s1;
				cmd_op    = CO_INSERT;
				used_d    = used_q + CNT_W'(1);
			end
			default: ;
		endcase
		cmd.op     = advance ? cmd_op : CO_HOLD;
		cmd.idx    = act_q.idx;
		cmd.start  = addr_s1;
		cmd.length = len_s1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		advance  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: state_d = S_SEL;
			S_SEL: state_d = S_RD;
			S_RD:  state_d = S_ACT;
			S_ACT: begin
				// hold here while the previous result is still stalled
				if (!out_valid_q || !out_stall) begin
					advance = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				used_q      <= used_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q       <= res_status;
			entry_index_q  <= res_idx;
			ref_count_q    <= res_count;
			region_start_q <= res_start;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_index  = entry_index_q;
	assign ref_count    = ref_count_q;
	assign region_start = region_start_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_REGIONS))
		else $error("region count above table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && act_q.kind == AK_INSERT) |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && act_q.kind == AK_CLEAR) |=> used_q == '0)
		else $error("clear left regions behind");

	a_result_from_act: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_ACT))
		else $error("result raised outside the act step");

	a_single_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> $onehot0(act_q.oh))
		else $error("more than one cell selected");
`endif

endmodule
